### design/ptfa_pkg.sv
package ptfa_pkg;

  // Default table depth
  localparam int unsigned SLOTS_DEF = 4;

  // Field widths
  localparam int unsigned BYTE_W    = 31;
  localparam int unsigned HDR_W     = 13;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned NAME_W    = 64;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 31;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;

  // Register reset values
  localparam logic [BYTE_W-1:0] DISK_RST = '0;
  localparam logic [HDR_W-1:0]  HDR_RST  = 13'd128;
  localparam logic [MODE_W-1:0] MODE_RST = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  // Placement policies (code three behaves as first fit)
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_EXT   = 3'd2,
    STAT_SPACE = 3'd3,
    STAT_NAME  = 3'd4,
    STAT_NOFIT = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_DRAIN,
    S_DONE
  } ctrl_state_e;

  // One partition table entry
  typedef struct packed {
    logic              active;
    logic              ext;
    logic [BYTE_W-1:0] start;
    logic [BYTE_W-1:0] length;
    logic [NAME_W-1:0] name;
  } entry_t;

  // Commands to the hole evaluator
  typedef struct packed {
    logic clear;
    logic load_entry;
    logic load_final;
  } walk_ctrl_t;

endpackage

### design/ptfa_cell.sv
module ptfa_cell #(
  parameter int unsigned IdW = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptfa_pkg::cell_op_e  op_i,
  input  ptfa_pkg::entry_t    new_i,
  input  logic [IdW-1:0]      new_id_i,
  input  ptfa_pkg::entry_t    left_i,
  input  logic [IdW-1:0]      left_id_i,
  input  logic                left_after_i,
  input  ptfa_pkg::entry_t    right_i,
  input  logic [IdW-1:0]      right_id_i,
  output ptfa_pkg::entry_t    entry_o,
  output logic [IdW-1:0]      id_o,
  output logic                after_o
);

  logic                        act_q, ext_q;
  logic [ptfa_pkg::BYTE_W-1:0] start_q, len_q;
  logic [ptfa_pkg::NAME_W-1:0] name_q;
  ptfa_pkg::entry_t            ent_q, ent_d;
  logic [IdW-1:0]              id_q, id_d;

  // Registered entry seen as one record
  assign ent_q = {act_q, ext_q, start_q, len_q, name_q};

  // This entry sorts after the new one: free, later start, or same start and higher slot
  assign after_o = !ent_q.active ||
                   (ent_q.start > new_i.start) ||
                   ((ent_q.start == new_i.start) && (id_q > new_id_i));

  // Rotate toward the head, or open a gap for the new entry
  always_comb begin
    ent_d = ent_q;
    id_d  = id_q;
    case (op_i)
      ptfa_pkg::CELL_ROTATE: begin
        ent_d = right_i;
        id_d  = right_id_i;
      end
      ptfa_pkg::CELL_INSERT: begin
        if (left_after_i) begin
          ent_d = left_i;
          id_d  = left_id_i;
        end else if (after_o) begin
          ent_d = new_i;
          id_d  = new_id_i;
        end
      end
      default: begin
        ent_d = ent_q;
        id_d  = id_q;
      end
    endcase
  end

  // Flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ext_q <= 1'b0;
    end else begin
      act_q <= ent_d.active;
      ext_q <= ent_d.ext;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    start_q <= ent_d.start;
    len_q   <= ent_d.length;
    name_q  <= ent_d.name;
    id_q    <= id_d;
  end

  assign entry_o = ent_q;
  assign id_o    = id_q;

endmodule

### design/ptfa_hole_unit.sv
module ptfa_hole_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptfa_pkg::walk_ctrl_t            ctrl_i,
  input  logic                            head_active_i,
  input  logic [ptfa_pkg::BYTE_W-1:0]     head_start_i,
  input  logic [ptfa_pkg::BYTE_W-1:0]     head_length_i,
  input  logic [ptfa_pkg::BYTE_W-1:0]     disk_size_i,
  input  logic [ptfa_pkg::HDR_W-1:0]      header_size_i,
  input  logic [ptfa_pkg::BYTE_W-1:0]     req_i,
  input  logic [ptfa_pkg::MODE_W-1:0]     fit_mode_i,
  output logic                            found_o,
  output logic [ptfa_pkg::BYTE_W-1:0]     best_start_o
);

  localparam int unsigned CurW  = ptfa_pkg::BYTE_W + 1;
  localparam int unsigned SizeW = ptfa_pkg::BYTE_W + 2;

  // Stage 1: hole size from the cursor
  logic [CurW-1:0]            cursor_q, cursor_d;
  logic [SizeW-1:0]           size1_q, size1_d;
  logic [ptfa_pkg::BYTE_W-1:0] hstart1_q, hstart1_d;
  logic                       v1_q, v1_d;

  // Stage 2: fit selection
  logic                       found_q, found_d;
  logic [CurW-1:0]            best_size_q, best_size_d;
  logic [ptfa_pkg::BYTE_W-1:0] best_start_q, best_start_d;
  logic                       take, better;

  // Stage 1: next hole ends at the head's start, or at the disk end
  always_comb begin
    cursor_d  = cursor_q;
    size1_d   = size1_q;
    hstart1_d = hstart1_q;
    v1_d      = 1'b0;
    if (ctrl_i.clear) begin
      cursor_d = CurW'(header_size_i);
    end else if (ctrl_i.load_entry && head_active_i) begin
      size1_d   = {2'b00, head_start_i} - {1'b0, cursor_q};
      hstart1_d = cursor_q[ptfa_pkg::BYTE_W-1:0];
      cursor_d  = {1'b0, head_start_i} + {1'b0, head_length_i};
      v1_d      = 1'b1;
    end else if (ctrl_i.load_final) begin
      size1_d   = {2'b00, disk_size_i} - {1'b0, cursor_q};
      hstart1_d = cursor_q[ptfa_pkg::BYTE_W-1:0];
      v1_d      = 1'b1;
    end
  end

  // Stage 2: positive hole large enough; replace only on strict improvement
  always_comb begin
    take   = !size1_q[SizeW-1] && (size1_q != '0) &&
             (size1_q[CurW-1:0] >= {1'b0, req_i});
    better = ((fit_mode_i == ptfa_pkg::FIT_BEST) && (size1_q[CurW-1:0] < best_size_q)) ||
             ((fit_mode_i == ptfa_pkg::FIT_WORST) && (size1_q[CurW-1:0] > best_size_q));
    found_d      = found_q;
    best_size_d  = best_size_q;
    best_start_d = best_start_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (v1_q && take) begin
      if (!found_q || better) begin
        found_d      = 1'b1;
        best_size_d  = size1_q[CurW-1:0];
        best_start_d = hstart1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q    <= v1_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q     <= cursor_d;
    size1_q      <= size1_d;
    hstart1_q    <= hstart1_d;
    best_size_q  <= best_size_d;
    best_start_q <= best_start_d;
  end

  assign found_o      = found_q;
  assign best_start_o = best_start_q;

endmodule

### design/partition_table_fit_allocator.sv
// Partition table allocator: one create request in, one status result out.
// The table rotates once through the cell chain, one entry a cycle, then the tail
// and drain states settle the fit and the done state registers the result once the output register is free.
// A new request is accepted only in idle, after the last result has been committed.
// Reset: table empty, disk_size 0, header_size 128, fit_mode first fit.
module partition_table_fit_allocator #(
  parameter int unsigned SLOTS = ptfa_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [ptfa_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [ptfa_pkg::CFG_W-1:0]          cfg_wdata_i,
  // Requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [30:0] request_bytes, [94:31] name_key, [95] zero
  input  logic [ptfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] part_kind
  input  logic                                s_axis_tuser,
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] status, [33:3] start_byte, [39:34] zero
  output logic [ptfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned IdW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned UsedW = ptfa_pkg::BYTE_W + IdW;
  localparam int unsigned OutPad = ptfa_pkg::OUT_TDATA_W - ptfa_pkg::STATUS_W
                                   - ptfa_pkg::BYTE_W;

  // Configuration registers
  logic [ptfa_pkg::BYTE_W-1:0] disk_q;
  logic [ptfa_pkg::HDR_W-1:0]  hdr_q;
  logic [ptfa_pkg::MODE_W-1:0] mode_q;

  // Request registers
  logic                        kind_q;
  logic [ptfa_pkg::BYTE_W-1:0] req_q;
  logic [ptfa_pkg::NAME_W-1:0] key_q;

  // Control
  ptfa_pkg::ctrl_state_e state_q, state_d;
  logic [IdW-1:0]        cnt_q, cnt_d;
  logic                  accept, out_free, commit;
  ptfa_pkg::cell_op_e    cell_op;
  ptfa_pkg::walk_ctrl_t  walk;

  // Walk accumulators
  logic [UsedW-1:0]      used_q, used_d;
  logic                  ext_seen_q, ext_seen_d;
  logic                  name_hit_q, name_hit_d;
  logic [SLOTS-1:0]      id_mask_q, id_mask_d;
  logic                  no_space_q, no_space_d;
  logic [IdW-1:0]        free_id_q, free_id_d;

  // Cell chain
  ptfa_pkg::entry_t      ent [SLOTS];
  logic [IdW-1:0]        ids [SLOTS];
  logic [SLOTS-1:0]      after;
  ptfa_pkg::entry_t      new_ent;

  // Fit result and decision
  logic                        found;
  logic [ptfa_pkg::BYTE_W-1:0] best_start;
  ptfa_pkg::status_e           status;

  // Output register
  logic                         out_valid_q;
  logic [ptfa_pkg::OUT_TDATA_W-1:0] out_data_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= ptfa_pkg::DISK_RST;
      hdr_q  <= ptfa_pkg::HDR_RST;
      mode_q <= ptfa_pkg::MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ptfa_pkg::CFG_DISK: disk_q <= cfg_wdata_i;
        ptfa_pkg::CFG_HDR:  hdr_q  <= cfg_wdata_i[ptfa_pkg::HDR_W-1:0];
        ptfa_pkg::CFG_MODE: mode_q <= cfg_wdata_i[ptfa_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      req_q  <= s_axis_tdata[ptfa_pkg::BYTE_W-1:0];
      key_q  <= s_axis_tdata[ptfa_pkg::BYTE_W +: ptfa_pkg::NAME_W];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ptfa_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ptfa_pkg::S_WALK;
          cnt_d   = '0;
        end
      end
      ptfa_pkg::S_WALK: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IdW'(SLOTS - 1)) begin
          state_d = ptfa_pkg::S_TAIL;
        end
      end
      ptfa_pkg::S_TAIL:  state_d = ptfa_pkg::S_DRAIN;
      ptfa_pkg::S_DRAIN: state_d = ptfa_pkg::S_DONE;
      ptfa_pkg::S_DONE: begin
        if (out_free) begin
          state_d = ptfa_pkg::S_IDLE;
        end
      end
      default: state_d = ptfa_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    cell_op         = ptfa_pkg::CELL_HOLD;
    walk            = '0;
    commit          = 1'b0;
    case (state_q)
      ptfa_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        walk.clear    = accept;
      end
      ptfa_pkg::S_WALK: begin
        cell_op         = ptfa_pkg::CELL_ROTATE;
        walk.load_entry = 1'b1;
      end
      ptfa_pkg::S_TAIL: begin
        walk.load_final = 1'b1;
      end
      ptfa_pkg::S_DONE: begin
        commit = out_free;
        if (out_free && (status == ptfa_pkg::STAT_OK)) begin
          cell_op = ptfa_pkg::CELL_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptfa_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Table checks gathered as entries pass the head cell
  always_comb begin
    used_d     = used_q;
    ext_seen_d = ext_seen_q;
    name_hit_d = name_hit_q;
    id_mask_d  = id_mask_q;
    no_space_d = no_space_q;
    free_id_d  = free_id_q;
    if (walk.clear) begin
      used_d     = '0;
      ext_seen_d = 1'b0;
      name_hit_d = 1'b0;
      id_mask_d  = '0;
    end else if (walk.load_entry && ent[0].active) begin
      used_d          = used_q + UsedW'(ent[0].length);
      ext_seen_d      = ext_seen_q || ent[0].ext;
      name_hit_d      = name_hit_q || (ent[0].name == key_q);
      id_mask_d[ids[0]] = 1'b1;
    end
    if (walk.load_final) begin
      no_space_d = ({1'b0, used_q} + (UsedW + 1)'(req_q)) > (UsedW + 1)'(disk_q);
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!id_mask_q[i]) begin
          free_id_d = IdW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    used_q     <= used_d;
    ext_seen_q <= ext_seen_d;
    name_hit_q <= name_hit_d;
    id_mask_q  <= id_mask_d;
    no_space_q <= no_space_d;
    free_id_q  <= free_id_d;
  end

  // Result code in check order; table is full when the tail cell is in use
  always_comb begin
    if (ent[SLOTS-1].active) begin
      status = ptfa_pkg::STAT_FULL;
    end else if (kind_q && ext_seen_q) begin
      status = ptfa_pkg::STAT_EXT;
    end else if (no_space_q) begin
      status = ptfa_pkg::STAT_SPACE;
    end else if (name_hit_q) begin
      status = ptfa_pkg::STAT_NAME;
    end else if (!found) begin
      status = ptfa_pkg::STAT_NOFIT;
    end else begin
      status = ptfa_pkg::STAT_OK;
    end
  end

  // Entry to insert
  always_comb begin
    new_ent.active = 1'b1;
    new_ent.ext    = kind_q;
    new_ent.start  = best_start;
    new_ent.length = req_q;
    new_ent.name   = key_q;
  end

  // Cell chain, kept sorted by start then slot number, free entries at the tail
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    localparam int unsigned Right = (k + 1) % SLOTS;
    if (k == 0) begin : g_head
      ptfa_cell #(.IdW(IdW)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (cell_op),
        .new_i        (new_ent),
        .new_id_i     (free_id_q),
        .left_i       (new_ent),
        .left_id_i    (free_id_q),
        .left_after_i (1'b0),
        .right_i      (ent[Right]),
        .right_id_i   (ids[Right]),
        .entry_o      (ent[k]),
        .id_o         (ids[k]),
        .after_o      (after[k])
      );
    end else begin : g_body
      ptfa_cell #(.IdW(IdW)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (cell_op),
        .new_i        (new_ent),
        .new_id_i     (free_id_q),
        .left_i       (ent[k-1]),
        .left_id_i    (ids[k-1]),
        .left_after_i (after[k-1]),
        .right_i      (ent[Right]),
        .right_id_i   (ids[Right]),
        .entry_o      (ent[k]),
        .id_o         (ids[k]),
        .after_o      (after[k])
      );
    end
  end

  // Hole evaluation
  ptfa_hole_unit u_hole (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (walk),
    .head_active_i (ent[0].active),
    .head_start_i  (ent[0].start),
    .head_length_i (ent[0].length),
    .disk_size_i   (disk_q),
    .header_size_i (hdr_q),
    .req_i         (req_q),
    .fit_mode_i    (mode_q),
    .found_o       (found),
    .best_start_o  (best_start)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {OutPad'(0),
                     (status == ptfa_pkg::STAT_OK) ? best_start : '0,
                     status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
